[rtl/core/tlpt_pkg.sv]
// ============================================================================
// Two-level page table mapper package
// Shared constants, codes and handshake structs for the mapper core.
// ============================================================================
`default_nettype none

package tlpt_pkg;

    localparam int ADDR_W          = 32;
    localparam int IDX_W           = 10;
    localparam int DIR_ENTRIES     = 1024;
    localparam int PAGE_SHIFT      = 12;
    localparam int DEF_TABLE_SLOTS = 16;

    localparam logic [ADDR_W-1:0]     ABSENT_VALUE = 32'h0000_0002;
    localparam logic [PAGE_SHIFT-1:0] FLAGS_PW     = 12'h003;

    typedef enum logic [1:0] {
        STATUS_MAPPED = 2'd0,
        STATUS_NEW    = 2'd1,
        STATUS_FULL   = 2'd2
    } tlpt_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_RESULT
    } tlpt_state_t;

    // Requests from the sequencer to the table store.
    typedef struct packed {
        logic fill_start;
        logic wr_en;
    } tlpt_tbl_ctrl_t;

    // Progress of the table store's fill sweep.
    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } tlpt_tbl_stat_t;

endpackage

`default_nettype wire

[rtl/core/tlpt_table_store.sv]
// ============================================================================
// Page table store
// Holds every table slot in one synchronous memory and runs the 1024-entry
// fill sweep: identity map of slot 0 after reset, not-present words on
// allocation of a new slot.
// ============================================================================
`default_nettype none

module tlpt_table_store
    import tlpt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int SLOT_W      = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tlpt_tbl_ctrl_t      ctrl,
    input  wire logic [SLOT_W-1:0]   wr_slot,
    input  wire logic [IDX_W-1:0]    wr_index,
    input  wire logic [ADDR_W-1:0]   wr_data,
    output tlpt_tbl_stat_t           stat
);

    localparam int DEPTH = TABLE_SLOTS * DIR_ENTRIES;

    logic [ADDR_W-1:0] mem [DEPTH];

    logic              busy_reg, busy_next;
    logic              ident_reg, ident_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic                    we;
    logic [SLOT_W+IDX_W-1:0] waddr;
    logic [ADDR_W-1:0]       wdata;

    always_comb begin
        busy_next  = busy_reg;
        ident_next = ident_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        we         = 1'b0;
        waddr      = {wr_slot, wr_index};
        wdata      = wr_data;
        if (busy_reg) begin
            we    = 1'b1;
            waddr = {slot_reg, idx_reg};
            // Slot 0 after reset maps the first 4 MiB one to one.
            wdata = ident_reg ? {{(ADDR_W-IDX_W-PAGE_SHIFT){1'b0}}, idx_reg, FLAGS_PW}
                              : ABSENT_VALUE;
            idx_next = idx_reg + 1'b1;
            if (idx_reg == IDX_W'(DIR_ENTRIES - 1)) begin
                busy_next  = 1'b0;
                ident_next = 1'b0;
            end
        end else if (ctrl.fill_start) begin
            busy_next = 1'b1;
            slot_next = wr_slot;
            idx_next  = '0;
        end else if (ctrl.wr_en) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            ident_reg <= 1'b1;
            slot_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            ident_reg <= ident_next;
            slot_reg  <= slot_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.idx  = idx_reg;

endmodule

`default_nettype wire

[rtl/core/two_level_page_table_mapper.sv]
// A request passes through the LOOKUP and RESULT states when the directory entry is
// present or the pool is exhausted; an allocation also passes through FILL, which waits
// for the 1024-entry fill sweep over the single write port of the table memory.
// One request is in flight at a time; the next is taken only after its result is loaded.
// After reset an initialisation pass clears the directory and identity-maps
// slot 0; s_ready stays low during it, while configuration writes are taken.
// ============================================================================
// Two-level page table mapper
// Maps virtual pages into a directory/table hierarchy, allocating tables from
// a fixed pool of slots and reporting when that pool runs out.
// ============================================================================
`default_nettype none

module two_level_page_table_mapper
    import tlpt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [ADDR_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ADDR_W-1:0] s_virtual_addr,
    input  wire logic [ADDR_W-1:0] s_physical_addr,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [IDX_W-1:0]       m_dir_index,
    output logic [IDX_W-1:0]       m_table_index,
    output logic [ADDR_W-1:0]      m_dir_entry,
    output logic [ADDR_W-1:0]      m_table_entry
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NEXT_W = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_W  = SLOT_W + 1;
    localparam int BASE_W = ADDR_W - PAGE_SHIFT;

    // Directory memory: present bit above the slot number.
    logic [DIR_W-1:0] dir_mem [DIR_ENTRIES];
    logic [DIR_W-1:0] dir_rd_reg;
    logic             dir_we;
    logic [IDX_W-1:0] dir_waddr;
    logic [DIR_W-1:0] dir_wdata;

    tlpt_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] base_reg;
    logic [NEXT_W-1:0] next_free_reg, next_free_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    tlpt_status_t      status_reg, status_next;
    logic [IDX_W-1:0]  di_reg, ti_reg;
    logic [ADDR_W-1:0] entry_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [IDX_W-1:0]  m_dir_index_reg, m_table_index_reg;
    logic [ADDR_W-1:0] m_dir_entry_reg, m_table_entry_reg;

    tlpt_tbl_ctrl_t    tbl_ctrl;
    tlpt_tbl_stat_t    tbl_stat;
    logic [SLOT_W-1:0] tbl_slot;

    logic              accept;
    logic              load_out;
    logic              dir_present;
    logic [SLOT_W-1:0] dir_slot;
    logic              pool_full;
    logic [BASE_W-1:0] table_page;

    assign accept      = s_valid && s_ready;
    assign dir_present = dir_rd_reg[DIR_W-1];
    assign dir_slot    = dir_rd_reg[SLOT_W-1:0];
    assign pool_full   = next_free_reg >= NEXT_W'(TABLE_SLOTS);

    tlpt_table_store #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_table_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (tbl_ctrl),
        .wr_slot  (tbl_slot),
        .wr_index (ti_reg),
        .wr_data  (entry_reg),
        .stat     (tbl_stat)
    );

    always_comb begin
        state_next     = state_reg;
        next_free_next = next_free_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        dir_we         = 1'b0;
        dir_waddr      = di_reg;
        dir_wdata      = '0;
        tbl_ctrl       = '0;
        tbl_slot       = slot_reg;
        s_ready        = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_INIT: begin
                // Directory is cleared in step with the table store's sweep.
                dir_we    = 1'b1;
                dir_waddr = tbl_stat.idx;
                dir_wdata = (tbl_stat.idx == '0) ? {1'b1, {SLOT_W{1'b0}}} : '0;
                if (!tbl_stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (dir_present) begin
                    // A slot number beyond the pool falls back to slot 0.
                    slot_next      = ({1'b0, dir_slot} >= (SLOT_W+1)'(TABLE_SLOTS))
                                     ? '0 : dir_slot;
                    tbl_slot       = slot_next;
                    tbl_ctrl.wr_en = 1'b1;
                    status_next    = STATUS_MAPPED;
                    state_next     = ST_RESULT;
                end else if (pool_full) begin
                    status_next = STATUS_FULL;
                    state_next  = ST_RESULT;
                end else begin
                    slot_next           = next_free_reg[SLOT_W-1:0];
                    tbl_slot            = slot_next;
                    tbl_ctrl.fill_start = 1'b1;
                    dir_we              = 1'b1;
                    dir_wdata           = {1'b1, slot_next};
                    next_free_next      = next_free_reg + 1'b1;
                    status_next         = STATUS_NEW;
                    state_next          = ST_FILL;
                end
            end
            ST_FILL: begin
                if (!tbl_stat.busy) begin
                    tbl_ctrl.wr_en = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            next_free_reg <= NEXT_W'(1);
            base_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        status_reg <= status_next;
        if (accept) begin
            di_reg    <= s_virtual_addr[ADDR_W-1 -: IDX_W];
            ti_reg    <= s_virtual_addr[PAGE_SHIFT +: IDX_W];
            entry_reg <= s_physical_addr | {{BASE_W{1'b0}}, FLAGS_PW};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dir_rd_reg <= dir_mem[s_virtual_addr[ADDR_W-1 -: IDX_W]];
        end
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
    end

    // Table address uses the base as it stands now; its low 12 bits are ignored.
    assign table_page = base_reg[ADDR_W-1:PAGE_SHIFT] + BASE_W'(slot_reg);

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg      <= status_reg;
            m_dir_index_reg   <= di_reg;
            m_table_index_reg <= ti_reg;
            if (status_reg == STATUS_FULL) begin
                m_dir_entry_reg   <= ABSENT_VALUE;
                m_table_entry_reg <= '0;
            end else begin
                m_dir_entry_reg   <= {table_page, FLAGS_PW};
                m_table_entry_reg <= entry_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_dir_index   = m_dir_index_reg;
    assign m_table_index = m_table_index_reg;
    assign m_dir_entry   = m_dir_entry_reg;
    assign m_table_entry = m_table_entry_reg;

`ifndef ASSERT_OFF
    a_no_write_during_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_ctrl.wr_en |-> !tbl_stat.busy)
        else $error("table write collides with fill sweep");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= NEXT_W'(TABLE_SLOTS))
        else $error("free slot counter ran past the pool");

    a_result_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result appeared outside the result state");

    a_alloc_starts_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_ctrl.fill_start |=> tbl_stat.busy && state_reg == ST_FILL)
        else $error("allocation did not start a fill sweep");
`endif

endmodule

`default_nettype wire

[tb/page_map_checker.sv]
// ============================================================================
// Page table mapping checker
// Watches the request and result channels of the mapper and keeps its own
// copy of the directory, the slot pool and the pool base. It works out the
// result of every accepted request and compares the returned transfers with
// the expected ones, field by field and in order.
// ============================================================================
module page_map_checker
    import tlpt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [ADDR_W-1:0] s_virtual_addr,
    input  logic [ADDR_W-1:0] s_physical_addr,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_status,
    input  logic [IDX_W-1:0]  m_dir_index,
    input  logic [IDX_W-1:0]  m_table_index,
    input  logic [ADDR_W-1:0] m_dir_entry,
    input  logic [ADDR_W-1:0] m_table_entry,
    output int                mismatch_count,
    output int                maps_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        tlpt_status_t      status;
        logic [IDX_W-1:0]  dir_index;
        logic [IDX_W-1:0]  table_index;
        logic [ADDR_W-1:0] dir_entry;
        logic [ADDR_W-1:0] table_entry;
    } page_map_t;

    logic              dir_present [DIR_ENTRIES];
    int unsigned       dir_slot [DIR_ENTRIES];
    int unsigned       next_free_slot;
    logic [ADDR_W-1:0] pool_base;
    page_map_t         expected_maps [$];

    // Directory entry 0 starts out present and points at slot 0.
    task automatic clear_directory();
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            dir_present[i] = 1'b0;
            dir_slot[i]    = 0;
        end
        dir_present[0] = 1'b1;
        next_free_slot = 1;
        pool_base      = '0;
    endtask

    function automatic page_map_t predict_mapping(input logic [ADDR_W-1:0] vaddr,
                                                  input logic [ADDR_W-1:0] paddr);
        page_map_t         res;
        logic [IDX_W-1:0]  di;
        logic [ADDR_W-1:0] table_addr;
        di              = vaddr[31:22];
        res.dir_index   = di;
        res.table_index = vaddr[21:12];
        if (!dir_present[di]) begin
            if (next_free_slot >= TABLE_SLOTS) begin
                // Pool used up: nothing is written and the entry stays absent.
                res.status      = STATUS_FULL;
                res.dir_entry   = ABSENT_VALUE;
                res.table_entry = '0;
                return res;
            end
            dir_present[di] = 1'b1;
            dir_slot[di]    = next_free_slot;
            next_free_slot  = next_free_slot + 1;
            res.status      = STATUS_NEW;
        end else begin
            res.status = STATUS_MAPPED;
        end
        // The base is taken as it stands now, and the sum wraps at 32 bits.
        table_addr      = {pool_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
                          + (ADDR_W'(dir_slot[di]) << PAGE_SHIFT);
        res.dir_entry   = table_addr | ADDR_W'(FLAGS_PW);
        res.table_entry = paddr | ADDR_W'(FLAGS_PW);
        return res;
    endfunction

    task automatic check_field(input string label, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        page_map_t want;
        if (!aresetn) begin
            clear_directory();
            expected_maps.delete();
            mismatch_count   = 0;
            maps_outstanding = 0;
        end else begin
            if (cfg_wr_en) begin
                pool_base = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (expected_maps.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got status %0d dir %h table %h",
                             $time, m_status, m_dir_entry, m_table_entry);
                    mismatch_count++;
                end else begin
                    want = expected_maps.pop_front();
                    check_field("status", ADDR_W'(want.status), ADDR_W'(m_status));
                    check_field("dir_index", ADDR_W'(want.dir_index), ADDR_W'(m_dir_index));
                    check_field("table_index", ADDR_W'(want.table_index),
                                ADDR_W'(m_table_index));
                    check_field("dir_entry", want.dir_entry, m_dir_entry);
                    check_field("table_entry", want.table_entry, m_table_entry);
                end
            end
            if (s_valid && s_ready) begin
                expected_maps.push_back(predict_mapping(s_virtual_addr, s_physical_addr));
            end
            maps_outstanding = expected_maps.size();
        end
    end

endmodule

[tb/testbench.sv]
// ============================================================================
// Page table mapper testbench
// Drives mapping requests and pool base writes into the mapper: a directed
// run through the special cases that uses up the whole table pool, then
// random requests under three patterns of idling on both channels. The
// checker beside the block does the prediction and comparison.
// ============================================================================
module testbench
    import tlpt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS  = DEF_TABLE_SLOTS;
    localparam int ITEMS_EACH   = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              cfg_wr_en       = 1'b0;
    logic [ADDR_W-1:0] cfg_wr_data     = '0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [ADDR_W-1:0] s_virtual_addr  = '0;
    logic [ADDR_W-1:0] s_physical_addr = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [1:0]        m_status;
    logic [IDX_W-1:0]  m_dir_index;
    logic [IDX_W-1:0]  m_table_index;
    logic [ADDR_W-1:0] m_dir_entry;
    logic [ADDR_W-1:0] m_table_entry;

    int                map_mismatches;
    int                maps_outstanding;
    int                cycle_count     = 0;
    int                snd_idle_pct    = 0;
    int                rcv_idle_pct    = 0;
    logic              hold_request    = 1'b0;
    logic [IDX_W-1:0]  live_dirs [$];

    two_level_page_table_mapper #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_virtual_addr (s_virtual_addr),
        .s_physical_addr(s_physical_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_dir_index    (m_dir_index),
        .m_table_index  (m_table_index),
        .m_dir_entry    (m_dir_entry),
        .m_table_entry  (m_table_entry)
    );

    page_map_checker #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) map_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_virtual_addr  (s_virtual_addr),
        .s_physical_addr (s_physical_addr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_dir_index     (m_dir_index),
        .m_table_index   (m_table_index),
        .m_dir_entry     (m_dir_entry),
        .m_table_entry   (m_table_entry),
        .mismatch_count  (map_mismatches),
        .maps_outstanding(maps_outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, or a long hold-off when one is asked for.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Valid is only lowered when a gap is actually taken, so it never drops and
    // rises again within one step.
    task automatic send_mapping(input logic [ADDR_W-1:0] vaddr,
                                input logic [ADDR_W-1:0] paddr);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_virtual_addr  <= vaddr;
        s_physical_addr <= paddr;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (maps_outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_pool_base(input logic [ADDR_W-1:0] base);
        wait_for_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct,
                                input logic [ADDR_W-1:0] base, input bit long_hold);
        logic [ADDR_W-1:0] vaddr;
        write_pool_base(base);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int n = 0; n < ITEMS_EACH; n++) begin
            // Mostly requests into live tables; the rest land anywhere and
            // usually find the pool empty.
            if ($urandom_range(99) < 70) begin
                vaddr = {live_dirs[$urandom_range(live_dirs.size() - 1)],
                         IDX_W'($urandom), PAGE_SHIFT'($urandom)};
            end else begin
                vaddr = $urandom;
            end
            send_mapping(vaddr, $urandom);
            if (long_hold && n == 0) begin
                hold_request = 1'b1;
            end
        end
    endtask

    initial begin
        snd_idle_pct = 36;
        rcv_idle_pct = 71;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Unaligned base: its low twelve bits must be ignored.
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 32'h0001_2345;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;

        send_mapping(32'h0000_0000, 32'h0000_0000);
        send_mapping(32'h003F_F000, 32'hFFFF_FFFF);
        send_mapping(32'hFFFF_FFFF, 32'h1234_5678);
        send_mapping(32'hFFC0_0000, 32'h0000_1000);
        send_mapping(32'h0040_0ABC, 32'hABCD_E123);
        live_dirs = '{10'd0, 10'd1023, 10'd1};

        // Base at the top of the address space, so slot addresses wrap to zero.
        write_pool_base(32'hFFFF_F000);
        send_mapping(32'hFFFF_F000, 32'h0000_0FFF);
        send_mapping(32'h0040_1000, 32'h8000_0000);

        // Take every remaining slot, then ask for one more table.
        for (int k = 0; k < TABLE_SLOTS - 3; k++) begin
            send_mapping({IDX_W'(2 + k), IDX_W'(k * 79), PAGE_SHIFT'(0)},
                         ADDR_W'(k) << PAGE_SHIFT);
            live_dirs.push_back(IDX_W'(2 + k));
        end
        send_mapping(32'h7FC0_1000, 32'hDEAD_B000);
        send_mapping(32'hFFF0_0000, 32'h0000_0001);

        random_phase(36, 71, 32'h0000_0000, 1'b0);
        random_phase(71, 36, 32'hFFFF_FFFF, 1'b0);
        random_phase(0, 0, $urandom, 1'b1);

        wait_for_results();
        repeat (8) @(negedge aclk);
        if (map_mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
